>>> src/rti_pkg.sv
// Shared types and constants of the RGB to I420 subsampler.
package rti_pkg;

  // Configuration register layout
  localparam int unsigned CFG_W = 13;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Default frame limits
  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Result queue depth; the back end issues only into free slots
  localparam int unsigned OUT_DEPTH = 4;

  localparam int unsigned COORD_W = 11;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // Channel sums of up to two pixels
  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } pair_sum_t;

  // Classified pixel request from front to back
  typedef struct packed {
    pixel_t             pix;
    logic               odd_x;
    logic               odd_y;
    logic               is_left;
    logic               wr_upper;
    logic               chroma_valid;
    logic               frame_last;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         luma;
    logic               chroma_valid;
    logic [7:0]         u_value;
    logic [7:0]         v_value;
    logic [COORD_W-1:0] chroma_column;
    logic [COORD_W-1:0] chroma_row;
    logic               frame_last;
  } res_t;

endpackage

>>> src/rti_fifo.sv
// Small first-word-fallthrough queue built from registers.
module rti_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               data_i,
  input  logic                           pop_i,
  output logic [WIDTH-1:0]               data_o,
  output logic                           full_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];
  assign count_o = count_q;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold payload in the slot being written
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/rti_front.sv
// Front end: raster position tracking and per-pixel classification.
module rti_front #(
  parameter int unsigned MAX_WIDTH  = rti_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rti_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned STORE_DEPTH = (MAX_WIDTH + 1) / 2,
  localparam int unsigned IDXW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  rti_pkg::pixel_t             pix_i,
  input  logic [rti_pkg::CFG_W-1:0]   cfg_width_i,
  input  logic [rti_pkg::CFG_W-1:0]   cfg_height_i,
  output rti_pkg::cmd_t               cmd_o,
  output logic [IDXW-1:0]             idx_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned WW = XW + 1;
  localparam int unsigned HW = YW + 1;

  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          row_end, last_row, is_left;

  // Clamp the frame size to 1..max
  always_comb begin
    if (cfg_width_i == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_i) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_i);
    end
    if (cfg_height_i == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_height_i) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height_i);
    end
  end

  assign row_end  = (({1'b0, x_q} + WW'(1)) >= w_eff);
  assign last_row = (({1'b0, y_q} + HW'(1)) >= h_eff);
  assign is_left  = !x_q[0] && !row_end;

  // Classify the pixel at the current position
  always_comb begin
    cmd_o.pix          = pix_i;
    cmd_o.odd_x        = x_q[0];
    cmd_o.odd_y        = y_q[0];
    cmd_o.is_left      = is_left;
    cmd_o.wr_upper     = !is_left && !y_q[0] && !last_row;
    cmd_o.chroma_valid = !is_left && (y_q[0] || last_row);
    cmd_o.frame_last   = row_end && last_row;
    cmd_o.col          = cmd_o.chroma_valid ? rti_pkg::COORD_W'(x_q >> 1) : '0;
    cmd_o.row          = cmd_o.chroma_valid ? rti_pkg::COORD_W'(y_q >> 1) : '0;
  end

  assign idx_o = IDXW'(x_q >> 1);

  // Advance the raster counters, wrapping at row and frame end
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (accept_i) begin
      if (row_end) begin
        x_d = '0;
        y_d = last_row ? '0 : y_q + YW'(1);
      end else begin
        x_d = x_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

endmodule

>>> src/rti_back.sv
// Back end: line store, block averaging, luma and chroma arithmetic.
module rti_back #(
  parameter int unsigned MAX_WIDTH = rti_pkg::MAX_WIDTH_DEF,
  localparam int unsigned STORE_DEPTH = (MAX_WIDTH + 1) / 2,
  localparam int unsigned IDXW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(rti_pkg::OUT_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  rti_pkg::cmd_t     cmd_i,
  input  logic [IDXW-1:0]   idx_i,
  output logic              cmd_pop_o,
  input  logic [CNTW-1:0]   out_count_i,
  output logic              res_push_o,
  output rti_pkg::res_t     res_o
);

  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;
  localparam logic signed [18:0] U_R = 19'sd43;
  localparam logic signed [18:0] U_G = 19'sd84;
  localparam logic signed [18:0] U_B = 19'sd127;
  localparam logic signed [18:0] V_R = 19'sd127;
  localparam logic signed [18:0] V_G = 19'sd106;
  localparam logic signed [18:0] V_B = 19'sd21;

  // Floor shift by 8, offset and clamp; a very negative sum wraps to the top
  function automatic logic [7:0] chroma_clamp(input logic signed [18:0] t);
    logic signed [10:0] q;
    q = $signed(t[18:8]) + 11'sd128;
    if (t < -19'sd65536) begin
      return 8'd255;
    end else if (q < 11'sd0) begin
      return 8'd0;
    end else if (q > 11'sd255) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

  typedef struct packed {
    logic                        odd_x;
    logic                        odd_y;
    logic                        chroma_valid;
    logic                        frame_last;
    logic [rti_pkg::COORD_W-1:0] col;
    logic [rti_pkg::COORD_W-1:0] row;
    logic [7:0]                  luma;
  } tag_t;

  rti_pkg::pair_sum_t line_mem [STORE_DEPTH];
  rti_pkg::pair_sum_t upper_q;
  rti_pkg::pixel_t    left_q;
  rti_pkg::pair_sum_t s_d, s1_q;
  tag_t               tag_d, tag1_q, tag2_q;
  logic               v1_q, v2_q;
  logic [CNTW:0]      occ;
  logic               issue;
  logic [15:0]        luma_sum;
  logic [9:0]         tot_r, tot_g, tot_b;
  logic [1:0]         shift;
  logic [9:0]         avg_r_q, avg_g_q, avg_b_q;
  logic signed [18:0] ar, ag, ab, tu, tv;
  logic [7:0]         u_val, v_val;

  // Issue only when the result queue has room for everything in flight
  assign occ = (CNTW + 1)'(out_count_i) + (CNTW + 1)'(v1_q) + (CNTW + 1)'(v2_q);
  assign issue = cmd_valid_i && (occ < (CNTW + 1)'(rti_pkg::OUT_DEPTH));
  assign cmd_pop_o = issue;

  // Pair sum with the left pixel and luma of the issued pixel
  always_comb begin
    s_d.r = {1'b0, cmd_i.pix.r} + (cmd_i.odd_x ? {1'b0, left_q.r} : 9'd0);
    s_d.g = {1'b0, cmd_i.pix.g} + (cmd_i.odd_x ? {1'b0, left_q.g} : 9'd0);
    s_d.b = {1'b0, cmd_i.pix.b} + (cmd_i.odd_x ? {1'b0, left_q.b} : 9'd0);
    luma_sum = LUMA_R * {8'd0, cmd_i.pix.r} + LUMA_G * {8'd0, cmd_i.pix.g}
             + LUMA_B * {8'd0, cmd_i.pix.b};
    tag_d.odd_x        = cmd_i.odd_x;
    tag_d.odd_y        = cmd_i.odd_y;
    tag_d.chroma_valid = cmd_i.chroma_valid;
    tag_d.frame_last   = cmd_i.frame_last;
    tag_d.col          = cmd_i.col;
    tag_d.row          = cmd_i.row;
    tag_d.luma         = luma_sum[15:8];
  end

  // Line store: write upper-row sums, read the entry for the lower row
  always_ff @(posedge clk_i) begin
    if (issue && cmd_i.wr_upper) begin
      line_mem[idx_i] <= s_d;
    end
    upper_q <= line_mem[idx_i];
  end

  // Hold the left pixel of the current pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (issue && cmd_i.is_left) begin
      left_q <= cmd_i.pix;
    end
  end

  // Add the upper row and divide by the pixel count
  always_comb begin
    tot_r = {1'b0, s1_q.r} + (tag1_q.odd_y ? {1'b0, upper_q.r} : 10'd0);
    tot_g = {1'b0, s1_q.g} + (tag1_q.odd_y ? {1'b0, upper_q.g} : 10'd0);
    tot_b = {1'b0, s1_q.b} + (tag1_q.odd_y ? {1'b0, upper_q.b} : 10'd0);
    shift = {1'b0, tag1_q.odd_x} + {1'b0, tag1_q.odd_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= s_d;
    tag1_q  <= tag_d;
    tag2_q  <= tag1_q;
    avg_r_q <= tot_r >> shift;
    avg_g_q <= tot_g >> shift;
    avg_b_q <= tot_b >> shift;
  end

  // Chroma from the block averages
  always_comb begin
    ar = $signed({9'd0, avg_r_q});
    ag = $signed({9'd0, avg_g_q});
    ab = $signed({9'd0, avg_b_q});
    tu = U_B * ab - U_R * ar - U_G * ag;
    tv = V_R * ar - V_G * ag - V_B * ab;
    u_val = chroma_clamp(tu);
    v_val = chroma_clamp(tv);
  end

  assign res_push_o          = v2_q;
  assign res_o.luma          = tag2_q.luma;
  assign res_o.chroma_valid  = tag2_q.chroma_valid;
  assign res_o.u_value       = tag2_q.chroma_valid ? u_val : 8'd0;
  assign res_o.v_value       = tag2_q.chroma_valid ? v_val : 8'd0;
  assign res_o.chroma_column = tag2_q.col;
  assign res_o.chroma_row    = tag2_q.row;
  assign res_o.frame_last    = tag2_q.frame_last;

endmodule

>>> src/rgb_to_i420_subsampler.sv
// Top level of the RGB to I420 converter with 2x2 chroma subsampling.
//
// Pixels of a frame enter in raster order on the push/full queue port, one
// request per accepted pixel. Every pixel gives one result on the empty/pop
// port: its luma, and on the pixel that completes a 2x2 block (or a partial
// block at an odd right or bottom edge) the block's U, V and block position.
// frame_last marks the last pixel of the frame.
// Throughput: one pixel per cycle while the receiver keeps popping; the back
// end issues one request per cycle while the result queue has room, and the
// line store takes at most one write and one registered read each.
// The front end counts raster position and classifies each pixel into a
// two-entry queue; the back end runs a three-stage pipeline into a
// four-entry result queue and issues only while that queue has room.
// When the receiver stalls, the result queue fills, issue stops, the
// request queue fills and full rises; nothing is dropped.
// Reset clears the raster counters, the left-pixel register and the queues
// and loads width 640 and height 480; the line store is not cleared, since
// each entry is written in an even row before an odd row reads it.
// image_width lies at byte address 0 and image_height at 4 of the APB port.
module rgb_to_i420_subsampler #(
  parameter int unsigned MAX_WIDTH  = rti_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = rti_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  luma_o,
  output logic        chroma_valid_o,
  output logic [7:0]  u_value_o,
  output logic [7:0]  v_value_o,
  output logic [10:0] chroma_column_o,
  output logic [10:0] chroma_row_o,
  output logic        frame_last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned STORE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned IDXW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CMDW = $bits(rti_pkg::cmd_t) + IDXW;
  localparam int unsigned RESW = $bits(rti_pkg::res_t);
  localparam int unsigned CNTW = $clog2(rti_pkg::OUT_DEPTH + 1);

  logic [rti_pkg::CFG_W-1:0] width_q, height_q;
  logic                      cfg_wr;
  logic                      accept;
  rti_pkg::pixel_t           pix;
  rti_pkg::cmd_t             front_cmd, back_cmd;
  logic [IDXW-1:0]           front_idx, back_idx;
  logic [CMDW-1:0]           q_rd_data;
  logic                      q_empty, cmd_pop;
  rti_pkg::res_t             res_in, res_out;
  logic                      res_push;
  logic [CNTW-1:0]           out_count;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rti_pkg::WIDTH_RESET;
      height_q <= rti_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == rti_pkg::REG_IMAGE_WIDTH) begin
        width_q <= pwdata[rti_pkg::CFG_W-1:0];
      end else begin
        height_q <= pwdata[rti_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      rti_pkg::REG_IMAGE_WIDTH:  prdata = {19'd0, width_q};
      rti_pkg::REG_IMAGE_HEIGHT: prdata = {19'd0, height_q};
      default:                   prdata = '0;
    endcase
  end

  // Front end
  assign accept = push && !full;
  assign pix.r  = red_i;
  assign pix.g  = green_i;
  assign pix.b  = blue_i;

  rti_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pix_i        (pix),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .cmd_o        (front_cmd),
    .idx_o        (front_idx)
  );

  // Request queue between front and back
  rti_fifo #(
    .WIDTH (CMDW),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({front_cmd, front_idx}),
    .pop_i   (cmd_pop),
    .data_o  (q_rd_data),
    .full_o  (full),
    .empty_o (q_empty),
    .count_o ()
  );

  assign back_cmd = q_rd_data[CMDW-1:IDXW];
  assign back_idx = q_rd_data[IDXW-1:0];

  // Back end
  rti_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (back_cmd),
    .idx_i       (back_idx),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue
  rti_fifo #(
    .WIDTH (RESW),
    .DEPTH (rti_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .full_o  (),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign luma_o          = res_out.luma;
  assign chroma_valid_o  = res_out.chroma_valid;
  assign u_value_o       = res_out.u_value;
  assign v_value_o       = res_out.v_value;
  assign chroma_column_o = res_out.chroma_column;
  assign chroma_row_o    = res_out.chroma_row;
  assign frame_last_o    = res_out.frame_last;

endmodule
